// ===== hw/rtl/rmq_pkg.sv =====
// Shared types and constants for the rotation-matrix-to-quaternion block.
// No dependencies.
`default_nettype none
package rmq_pkg;
    localparam int WORD_BITS_DEF = 16;

    typedef enum logic [1:0] {
        COMP_W = 2'd0,
        COMP_X = 2'd1,
        COMP_Y = 2'd2,
        COMP_Z = 2'd3
    } t_comp;

    typedef struct packed {
        logic  degen;
        t_comp best;
    } t_ctrl;

    localparam int CTRL_BITS = $bits(t_ctrl);
endpackage
`default_nettype wire

// ===== hw/rtl/rmq_front.sv =====
// Front end: forms the four estimates, picks the largest, builds the
// off-diagonal magnitudes and signs for the back end. Uses rmq_pkg.
`default_nettype none
module rmq_front #(
    parameter int WORD_BITS = rmq_pkg::WORD_BITS_DEF
) (
    input  wire logic [WORD_BITS-1:0]         i_r00,
    input  wire logic [WORD_BITS-1:0]         i_r01,
    input  wire logic [WORD_BITS-1:0]         i_r02,
    input  wire logic [WORD_BITS-1:0]         i_r10,
    input  wire logic [WORD_BITS-1:0]         i_r11,
    input  wire logic [WORD_BITS-1:0]         i_r12,
    input  wire logic [WORD_BITS-1:0]         i_r20,
    input  wire logic [WORD_BITS-1:0]         i_r21,
    input  wire logic [WORD_BITS-1:0]         i_r22,
    output rmq_pkg::t_ctrl                    o_ctrl,
    output logic [4*(WORD_BITS+1)+2:0]        o_data
);
    import rmq_pkg::*;

    localparam int W  = WORD_BITS;
    localparam int F  = W - 2;
    localparam int EW = W + 3;
    localparam int MB = W + 1;
    localparam logic signed [EW-1:0] ONE_E = {{(EW-1){1'b0}}, 1'b1} << F;

    logic signed [EW-1:0] e00, e11, e22, s0, s1, s2, s3, sb;
    logic signed [MB-1:0] da, db, dc, dd, de, df;
    logic signed [MB-1:0] d [0:2];
    logic [MB-1:0] mag [0:2];
    logic [2:0] neg;
    t_comp best;

    always_comb begin
        e00 = {{3{i_r00[W-1]}}, i_r00};
        e11 = {{3{i_r11[W-1]}}, i_r11};
        e22 = {{3{i_r22[W-1]}}, i_r22};
        s0 = ONE_E + e00 + e11 + e22;
        s1 = ONE_E + e00 - e11 - e22;
        s2 = ONE_E - e00 + e11 - e22;
        s3 = ONE_E - e00 - e11 + e22;
        best = COMP_W;
        sb = s0;
        if (s1 > sb) begin
            best = COMP_X;
            sb = s1;
        end
        if (s2 > sb) begin
            best = COMP_Y;
            sb = s2;
        end
        if (s3 > sb) begin
            best = COMP_Z;
            sb = s3;
        end
        da = {i_r21[W-1], i_r21} - {i_r12[W-1], i_r12};
        db = {i_r02[W-1], i_r02} - {i_r20[W-1], i_r20};
        dc = {i_r10[W-1], i_r10} - {i_r01[W-1], i_r01};
        dd = {i_r10[W-1], i_r10} + {i_r01[W-1], i_r01};
        de = {i_r02[W-1], i_r02} + {i_r20[W-1], i_r20};
        df = {i_r21[W-1], i_r21} + {i_r12[W-1], i_r12};
        case (best)
            COMP_W: begin
                d[0] = da; d[1] = db; d[2] = dc;
            end
            COMP_X: begin
                d[0] = da; d[1] = dd; d[2] = de;
            end
            COMP_Y: begin
                d[0] = db; d[1] = dd; d[2] = df;
            end
            default: begin
                d[0] = dc; d[1] = de; d[2] = df;
            end
        endcase
        for (int l = 0; l < 3; l++) begin
            neg[2-l] = d[l][MB-1];
            mag[l]   = d[l][MB-1] ? MB'(-d[l]) : MB'(d[l]);
        end
        o_ctrl.best  = best;
        o_ctrl.degen = sb[EW-1] || (sb == '0);
        o_data = {sb[MB-1:0], mag[0], mag[1], mag[2], neg};
    end
endmodule
`default_nettype wire

// ===== hw/rtl/rmq_queue.sv =====
// Two-entry queue between front and back ends. Uses rmq_pkg.
`default_nettype none
module rmq_queue #(
    parameter int DATA_BITS = 8
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_push,
    input  wire rmq_pkg::t_ctrl       i_ctrl,
    input  wire logic [DATA_BITS-1:0] i_data,
    output logic                      o_full,
    output logic                      o_valid,
    output rmq_pkg::t_ctrl            o_ctrl,
    output logic [DATA_BITS-1:0]      o_data,
    input  wire logic                 i_pop
);
    import rmq_pkg::*;

    localparam int EB = DATA_BITS + CTRL_BITS;

    logic [EB-1:0] r_mem [0:1];
    logic          r_wr, r_rd;
    logic [1:0]    r_cnt, n_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;
    assign {o_ctrl, o_data} = r_mem[r_rd];

    always_comb begin
        n_cnt = r_cnt;
        if (do_push && !do_pop) n_cnt = r_cnt + 2'd1;
        if (!do_push && do_pop) n_cnt = r_cnt - 2'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (do_push) r_wr <= !r_wr;
            if (do_pop)  r_rd <= !r_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= {i_ctrl, i_data};
    end
endmodule
`default_nettype wire

// ===== hw/rtl/rmq_back.sv =====
// Back end: pipelined square root, three pipelined restoring dividers,
// rounding, saturation and output register. Uses rmq_pkg.
`default_nettype none
module rmq_back #(
    parameter int WORD_BITS = rmq_pkg::WORD_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_q_valid,
    input  wire rmq_pkg::t_ctrl               i_ctrl,
    input  wire logic [4*(WORD_BITS+1)+2:0]   i_data,
    output logic                              o_pop,
    output logic [WORD_BITS-1:0]              o_q_w,
    output logic [WORD_BITS-1:0]              o_q_x,
    output logic [WORD_BITS-1:0]              o_q_y,
    output logic [WORD_BITS-1:0]              o_q_z,
    output logic                              o_degenerate,
    output logic                              o_valid,
    input  wire logic                         i_stall
);
    import rmq_pkg::*;

    localparam int W  = WORD_BITS;
    localparam int F  = W - 2;
    localparam int MB = W + 1;
    localparam int SQ = 2 * W;
    localparam int DW = 2 * W + 2;
    localparam int DB = 4 * MB + 3;
    localparam logic [MB-1:0] HALF  = {2'b01, {(W-1){1'b0}}};
    localparam logic [W-1:0]  MAXV  = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]  ONE_W = {2'b01, {(W-2){1'b0}}};

    logic en;

    // square-root stages
    logic [SQ-1:0] r_sn [0:W];
    logic [SQ-1:0] r_sr [0:W];
    logic [SQ-1:0] n_sn [1:W];
    logic [SQ-1:0] n_sr [1:W];
    t_ctrl         r_sc [0:W];
    logic [MB-1:0] r_sm [0:W][0:2];
    logic [2:0]    r_sg [0:W];
    logic          r_sv [0:W];

    // numerator stage
    logic [W-1:0]  r_ac, n_ac;
    logic [W+1:0]  r_aden, n_aden;
    logic [DW-1:0] r_anum [0:2];
    logic [DW-1:0] n_anum [0:2];
    logic [2:0]    r_ag;
    t_ctrl         r_actl;
    logic          r_av;

    // divider stages
    logic [DW-1:0] r_dr [0:W][0:2];
    logic [W-1:0]  r_dq [0:W][0:2];
    logic [DW-1:0] n_dr [1:W][0:2];
    logic [W-1:0]  n_dq [1:W][0:2];
    logic [2:0]    r_dov [0:W];
    logic [W+1:0]  r_dd [0:W];
    logic [W-1:0]  r_dc [0:W];
    logic [2:0]    r_dg [0:W];
    t_ctrl         r_dctl [0:W];
    logic          r_dv [0:W];

    logic [W-1:0] n_q [0:3];
    logic [W-1:0] lane_v [0:2];

    assign en    = !o_valid || !i_stall;
    assign o_pop = en;

    always_comb begin
        logic [SQ-1:0] bitv, t;
        for (int j = 0; j < W; j++) begin
            bitv = SQ'(1) << (2 * (W - 1 - j));
            t = r_sr[j] + bitv;
            if (r_sn[j] >= t) begin
                n_sn[j+1] = r_sn[j] - t;
                n_sr[j+1] = (r_sr[j] >> 1) + bitv;
            end else begin
                n_sn[j+1] = r_sn[j];
                n_sr[j+1] = r_sr[j] >> 1;
            end
        end
    end

    always_comb begin
        logic [SQ-1:0] rp;
        rp = r_sr[W] + SQ'(1);
        n_ac = rp[W:1];
        n_aden = {n_ac, 2'b00};
        for (int l = 0; l < 3; l++) begin
            n_anum[l] = DW'({r_sm[W][l], {F{1'b0}}}) + DW'(n_aden >> 1);
        end
    end

    always_comb begin
        logic [DW-1:0] sub;
        for (int t = 0; t < W; t++) begin
            sub = DW'(r_dd[t]) << (W - 1 - t);
            for (int l = 0; l < 3; l++) begin
                n_dq[t+1][l] = r_dq[t][l];
                if (r_dr[t][l] >= sub) begin
                    n_dr[t+1][l] = r_dr[t][l] - sub;
                    n_dq[t+1][l][W-1-t] = 1'b1;
                end else begin
                    n_dr[t+1][l] = r_dr[t][l];
                end
            end
        end
    end

    always_comb begin
        logic [MB-1:0] qf, lim, nl;
        for (int l = 0; l < 3; l++) begin
            qf  = r_dov[W][2-l] ? HALF : {1'b0, r_dq[W][l]};
            lim = (qf > HALF) ? HALF : qf;
            nl  = -lim;
            if (r_dg[W][2-l]) lane_v[l] = nl[W-1:0];
            else              lane_v[l] = (lim == HALF) ? MAXV : lim[W-1:0];
        end
        for (int i = 0; i < 4; i++) begin
            if (r_dctl[W].degen) begin
                n_q[i] = (i == 0) ? ONE_W : '0;
            end else if (i == int'(r_dctl[W].best)) begin
                n_q[i] = r_dc[W][W-1] ? MAXV : r_dc[W];
            end else if (i < int'(r_dctl[W].best)) begin
                n_q[i] = lane_v[i];
            end else begin
                n_q[i] = lane_v[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j <= W; j++) begin
                r_sv[j] <= 1'b0;
                r_dv[j] <= 1'b0;
            end
            r_av    <= 1'b0;
            o_valid <= 1'b0;
        end else if (en) begin
            r_sv[0] <= i_q_valid;
            for (int j = 1; j <= W; j++) begin
                r_sv[j] <= r_sv[j-1];
                r_dv[j] <= r_dv[j-1];
            end
            r_av    <= r_sv[W];
            r_dv[0] <= r_av;
            o_valid <= r_dv[W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sn[0] <= SQ'({i_data[DB-1 -: MB], {F{1'b0}}});
            r_sr[0] <= '0;
            r_sc[0] <= i_ctrl;
            for (int l = 0; l < 3; l++) r_sm[0][l] <= i_data[3 + (2 - l) * MB +: MB];
            r_sg[0] <= i_data[2:0];
            for (int j = 1; j <= W; j++) begin
                r_sn[j] <= n_sn[j];
                r_sr[j] <= n_sr[j];
                r_sc[j] <= r_sc[j-1];
                for (int l = 0; l < 3; l++) r_sm[j][l] <= r_sm[j-1][l];
                r_sg[j] <= r_sg[j-1];
            end
            r_ac   <= n_ac;
            r_aden <= n_aden;
            for (int l = 0; l < 3; l++) r_anum[l] <= n_anum[l];
            r_ag   <= r_sg[W];
            r_actl <= r_sc[W];
            for (int l = 0; l < 3; l++) begin
                r_dr[0][l]     <= r_anum[l];
                r_dq[0][l]     <= '0;
                r_dov[0][2-l]  <= (r_anum[l] >= (DW'(r_aden) << W));
            end
            r_dd[0]   <= r_aden;
            r_dc[0]   <= r_ac;
            r_dg[0]   <= r_ag;
            r_dctl[0] <= r_actl;
            for (int t = 1; t <= W; t++) begin
                for (int l = 0; l < 3; l++) begin
                    r_dr[t][l] <= n_dr[t][l];
                    r_dq[t][l] <= n_dq[t][l];
                end
                r_dov[t]  <= r_dov[t-1];
                r_dd[t]   <= r_dd[t-1];
                r_dc[t]   <= r_dc[t-1];
                r_dg[t]   <= r_dg[t-1];
                r_dctl[t] <= r_dctl[t-1];
            end
            o_q_w        <= n_q[0];
            o_q_x        <= n_q[1];
            o_q_y        <= n_q[2];
            o_q_z        <= n_q[3];
            o_degenerate <= r_dctl[W].degen;
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/rotation_matrix_to_quaternion.sv =====
// Top level: rotation matrix to quaternion (Shepperd), front end, queue,
// back end. Uses rmq_pkg, rmq_front, rmq_queue, rmq_back.
//
// channel  direction  handshake            payload
// matrix   in         i_valid / o_stall    i_r00 .. i_r22
// quat     out        o_valid / i_stall    o_q_w .. o_q_z, o_degenerate
//
// One matrix per cycle sustained while i_stall stays low; each accepted beat
// passes through the queue, then the one-bit-per-stage root and divider
// pipelines, the numerator register and the output register.
// Synchronous active-low reset clears the valids and the queue pointers and count.
// A stalled result freezes the back end; the two-entry queue keeps taking
// beats until it fills, then o_stall rises.
`default_nettype none
module rotation_matrix_to_quaternion #(
    parameter int WORD_BITS = rmq_pkg::WORD_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic [WORD_BITS-1:0] i_r00,
    input  wire logic [WORD_BITS-1:0] i_r01,
    input  wire logic [WORD_BITS-1:0] i_r02,
    input  wire logic [WORD_BITS-1:0] i_r10,
    input  wire logic [WORD_BITS-1:0] i_r11,
    input  wire logic [WORD_BITS-1:0] i_r12,
    input  wire logic [WORD_BITS-1:0] i_r20,
    input  wire logic [WORD_BITS-1:0] i_r21,
    input  wire logic [WORD_BITS-1:0] i_r22,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic [WORD_BITS-1:0]      o_q_w,
    output logic [WORD_BITS-1:0]      o_q_x,
    output logic [WORD_BITS-1:0]      o_q_y,
    output logic [WORD_BITS-1:0]      o_q_z,
    output logic                      o_degenerate
);
    import rmq_pkg::*;

    localparam int DB = 4 * (WORD_BITS + 1) + 3;
    localparam logic [WORD_BITS-1:0] ONE_W = {2'b01, {(WORD_BITS-2){1'b0}}};

    t_ctrl         f_ctrl, q_ctrl;
    logic [DB-1:0] f_data, q_data;
    logic          q_valid, b_pop;

    rmq_front #(.WORD_BITS(WORD_BITS)) u_front (
        .i_r00(i_r00), .i_r01(i_r01), .i_r02(i_r02),
        .i_r10(i_r10), .i_r11(i_r11), .i_r12(i_r12),
        .i_r20(i_r20), .i_r21(i_r21), .i_r22(i_r22),
        .o_ctrl(f_ctrl), .o_data(f_data)
    );

    rmq_queue #(.DATA_BITS(DB)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(i_valid), .i_ctrl(f_ctrl), .i_data(f_data),
        .o_full(o_stall), .o_valid(q_valid), .o_ctrl(q_ctrl), .o_data(q_data),
        .i_pop(b_pop)
    );

    rmq_back #(.WORD_BITS(WORD_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_q_valid(q_valid), .i_ctrl(q_ctrl), .i_data(q_data), .o_pop(b_pop),
        .o_q_w(o_q_w), .o_q_x(o_q_x), .o_q_y(o_q_y), .o_q_z(o_q_z),
        .o_degenerate(o_degenerate), .o_valid(o_valid), .i_stall(i_stall)
    );

    a_full_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> q_valid)
        else $error("queue full without a head beat");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_q_w) && $stable(o_q_x))
        else $error("stalled result beat changed");

    a_degen_identity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_degenerate |->
            o_q_w == ONE_W && o_q_x == '0 && o_q_y == '0 && o_q_z == '0)
        else $error("degenerate beat not identity");
endmodule
`default_nettype wire
